>>> hw/rtl/nalsc_pkg.sv
package nalsc_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int FIELD_W     = 24;
  localparam int SIZE_W      = 3;
  localparam int TDATA_W     = 80;

  typedef logic [OFFSET_BITS-1:0] pos_t;
  typedef logic [FIELD_W-1:0]     field_t;

  localparam pos_t POS_MAX = {OFFSET_BITS{1'b1}};

  localparam logic [SIZE_W-1:0] CODE_SIZE_SHORT = SIZE_W'(3);
  localparam logic [SIZE_W-1:0] CODE_SIZE_LONG  = SIZE_W'(4);

  typedef enum logic [1:0] {
    ST_RECORD   = 2'd0,
    ST_END      = 2'd1,
    ST_NO_CODE  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } item_t;

  typedef struct packed {
    field_t              code_offset;
    logic [SIZE_W-1:0]   code_size;
    field_t              payload_offset;
    field_t              payload_size;
    status_t             status;
    logic                is_last;
  } result_t;

  function automatic field_t to_field(pos_t v);
    logic [OFFSET_BITS+FIELD_W-1:0] ext;
    ext = {{FIELD_W{1'b0}}, v};
    return ext[FIELD_W-1:0];
  endfunction

endpackage

>>> hw/rtl/annexb_nal_start_code_scanner.sv
// A byte is held in the input register, scanned, and its result is registered for the master side.
// Throughput: one byte per cycle while the master side takes results; the scan state
// is updated once per byte between the input and result registers.
// Reset: synchronous, active high; clears the scan state and both register stages,
// so the next byte starts a new stream at offset 0.
module annexb_nal_start_code_scanner (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // data_byte
  input  logic                          s_axis_tlast,  // end_of_stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // code_offset[23:0], code_size[26:24], payload_offset[50:27], payload_size[74:51]
  output logic [nalsc_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic [1:0]                    m_axis_tuser,  // status
  output logic                          m_axis_tlast   // is_last
);
  import nalsc_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    can_load;
  logic    fire;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.data_byte     = s_axis_tdata;
  assign in_item.end_of_stream = s_axis_tlast;
  assign fire = item_valid && can_load;

  nalsc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .advance    (can_load)
  );

  nalsc_scan_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  nalsc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .res       (res),
    .can_load  (can_load),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = {5'b0, out_res.payload_size, out_res.payload_offset,
                         out_res.code_size, out_res.code_offset};
  assign m_axis_tuser = out_res.status;
  assign m_axis_tlast = out_res.is_last;

endmodule

>>> hw/rtl/nalsc_in_stage.sv
module nalsc_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  nalsc_pkg::item_t    in_item,
  output logic                item_valid,
  output nalsc_pkg::item_t    item,
  input  logic                advance
);
  import nalsc_pkg::*;

  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

>>> hw/rtl/nalsc_scan_core.sv
module nalsc_scan_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  nalsc_pkg::item_t     item,
  output logic                 res_valid,
  output nalsc_pkg::result_t   res
);
  import nalsc_pkg::*;

  pos_t              pos, pos_next;
  logic [23:0]       recent, recent_next;
  logic [1:0]        fresh, fresh_next;
  logic              unit_open, unit_open_next;
  pos_t              open_code_offset, open_code_offset_next;
  logic [SIZE_W-1:0] open_code_size, open_code_size_next;
  pos_t              open_payload_offset, open_payload_offset_next;
  logic              any_unit_seen, any_unit_seen_next;

  logic              saturated;
  logic              detect;
  logic              long_code;
  pos_t              code_start;
  pos_t              pos_inc;
  logic              close_prev;
  logic              close_at_end;

  assign saturated  = (pos == POS_MAX);
  assign detect     = (item.data_byte == 8'h01) && (fresh >= 2'd2)
                      && (recent[7:0] == 8'h00) && (recent[15:8] == 8'h00);
  assign long_code  = (fresh == 2'd3) && (recent[23:16] == 8'h00);
  assign code_start = long_code ? pos - pos_t'(3) : pos - pos_t'(2);
  assign pos_inc    = pos + pos_t'(1);
  assign close_prev = detect && unit_open && (code_start > open_payload_offset);
  assign close_at_end = !detect && unit_open && (pos_inc > open_payload_offset);

  always_comb begin
    pos_next                 = pos;
    recent_next              = recent;
    fresh_next               = fresh;
    unit_open_next           = unit_open;
    open_code_offset_next    = open_code_offset;
    open_code_size_next      = open_code_size;
    open_payload_offset_next = open_payload_offset;
    any_unit_seen_next       = any_unit_seen;
    res_valid                = 1'b0;
    res                      = '0;
    res.status               = ST_RECORD;
    if (fire) begin
      if (saturated) begin
        res_valid  = 1'b1;
        res.status = ST_OVERFLOW;
        res.is_last = item.end_of_stream;
      end else begin
        if (detect) begin
          if (close_prev) begin
            res_valid          = 1'b1;
            res.code_offset    = to_field(open_code_offset);
            res.code_size      = open_code_size;
            res.payload_offset = to_field(open_payload_offset);
            res.payload_size   = to_field(code_start - open_payload_offset);
            any_unit_seen_next = 1'b1;
          end
          unit_open_next           = 1'b1;
          open_code_offset_next    = code_start;
          open_code_size_next      = long_code ? CODE_SIZE_LONG : CODE_SIZE_SHORT;
          open_payload_offset_next = pos_inc;
          fresh_next               = 2'd0;
        end else if (fresh != 2'd3) begin
          fresh_next = fresh + 2'd1;
        end
        recent_next = {recent[15:0], item.data_byte};
        pos_next    = pos_inc;
        if (item.end_of_stream) begin
          if (!close_prev) begin
            if (close_at_end) begin
              res.code_offset    = to_field(open_code_offset);
              res.code_size      = open_code_size;
              res.payload_offset = to_field(open_payload_offset);
              res.payload_size   = to_field(pos_inc - open_payload_offset);
            end else begin
              res.status = any_unit_seen ? ST_END : ST_NO_CODE;
            end
          end
          res_valid   = 1'b1;
          res.is_last = 1'b1;
        end
      end
      if (item.end_of_stream) begin
        pos_next                 = '0;
        recent_next              = '0;
        fresh_next               = '0;
        unit_open_next           = 1'b0;
        open_code_offset_next    = '0;
        open_code_size_next      = '0;
        open_payload_offset_next = '0;
        any_unit_seen_next       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos                 <= '0;
      recent              <= '0;
      fresh               <= '0;
      unit_open           <= 1'b0;
      open_code_offset    <= '0;
      open_code_size      <= '0;
      open_payload_offset <= '0;
      any_unit_seen       <= 1'b0;
    end else begin
      pos                 <= pos_next;
      recent              <= recent_next;
      fresh               <= fresh_next;
      unit_open           <= unit_open_next;
      open_code_offset    <= open_code_offset_next;
      open_code_size      <= open_code_size_next;
      open_payload_offset <= open_payload_offset_next;
      any_unit_seen       <= any_unit_seen_next;
    end
  end

`ifndef SYNTHESIS
  a_eos_restarts: assert property (@(posedge clk) disable iff (rst)
    fire && item.end_of_stream |=> pos == '0 && !unit_open && !any_unit_seen)
    else $error("stream state not cleared after final byte");

  a_record_size: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_RECORD
      |-> (res.code_size == CODE_SIZE_SHORT || res.code_size == CODE_SIZE_LONG)
          && res.payload_size != '0)
    else $error("record with bad start code size or empty payload");

  a_eos_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire && item.end_of_stream |-> res_valid && res.is_last)
    else $error("final byte gave no closing result");

  a_open_unit_valid: assert property (@(posedge clk) disable iff (rst)
    unit_open |-> (open_code_size == CODE_SIZE_SHORT || open_code_size == CODE_SIZE_LONG))
    else $error("open unit has bad start code size");
`endif

endmodule

>>> hw/rtl/nalsc_out_stage.sv
module nalsc_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  nalsc_pkg::result_t   res,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_ready,
  output nalsc_pkg::result_t   out_res
);
  import nalsc_pkg::*;

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      out_res <= res;
    end
  end

endmodule

>>> bench/tb_annexb_nal_start_code_scanner.sv
module tb_annexb_nal_start_code_scanner;
  import nalsc_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = 8'h00;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]  m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                m_axis_tlast;

  annexb_nal_start_code_scanner u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  item_t   byte_queue[$];
  result_t unit_reports[$];

  int send_idle_pct = 7;
  int recv_idle_pct = 87;
  bit hold_ask      = 1'b0;
  bit hold_done     = 1'b0;
  int hold_left     = 0;
  bit byte_taken    = 1'b0;
  int quiet_cycles  = 0;
  int mismatches    = 0;
  int bytes_queued  = 0;
  int bytes_scanned = 0;
  int streams_done  = 0;
  int results_seen  = 0;
  int records_seen  = 0;

  // scanner shadow state
  pos_t              scan_pos;
  logic [23:0]       hist;
  logic [1:0]        fresh_cnt;
  bit                unit_open;
  pos_t              unit_code_off;
  logic [SIZE_W-1:0] unit_code_size;
  pos_t              unit_pay_off;
  bit                seen_unit;

  bit      emit;
  result_t report;
  result_t want;

  task automatic clear_scan();
    scan_pos       = '0;
    hist           = '0;
    fresh_cnt      = '0;
    unit_open      = 1'b0;
    unit_code_off  = '0;
    unit_code_size = '0;
    unit_pay_off   = '0;
    seen_unit      = 1'b0;
  endtask

  task automatic scan_byte(input item_t it, output bit has, output result_t r);
    pos_t              p;
    pos_t              code_at;
    logic [SIZE_W-1:0] sz;
    has = 1'b0;
    r   = '0;
    if (scan_pos >= POS_MAX) begin
      scan_pos  = POS_MAX;
      r.status  = ST_OVERFLOW;
      r.is_last = it.end_of_stream;
      has       = 1'b1;
      if (it.end_of_stream) clear_scan();
      return;
    end
    p = scan_pos;
    if (it.data_byte == 8'h01 && fresh_cnt >= 2'd2 && hist[15:0] == 16'h0000) begin
      sz = (fresh_cnt == 2'd3 && hist[23:16] == 8'h00) ? CODE_SIZE_LONG : CODE_SIZE_SHORT;
      code_at = p - pos_t'(sz - 3'd1);
      if (unit_open && code_at > unit_pay_off) begin
        r.code_offset    = unit_code_off;
        r.code_size      = unit_code_size;
        r.payload_offset = unit_pay_off;
        r.payload_size   = code_at - unit_pay_off;
        r.status         = ST_RECORD;
        seen_unit        = 1'b1;
        has              = 1'b1;
      end
      unit_open      = 1'b1;
      unit_code_off  = code_at;
      unit_code_size = sz;
      unit_pay_off   = p + 1'b1;
      fresh_cnt      = 2'd0;
    end else if (fresh_cnt < 2'd3) begin
      fresh_cnt = fresh_cnt + 2'd1;
    end
    hist     = {hist[15:0], it.data_byte};
    scan_pos = p + 1'b1;
    if (it.end_of_stream) begin
      if (!has) begin
        if (unit_open && p + 1'b1 > unit_pay_off) begin
          r.code_offset    = unit_code_off;
          r.code_size      = unit_code_size;
          r.payload_offset = unit_pay_off;
          r.payload_size   = p + 1'b1 - unit_pay_off;
          r.status         = ST_RECORD;
        end else begin
          r.status = seen_unit ? ST_END : ST_NO_CODE;
        end
      end
      r.is_last = 1'b1;
      has       = 1'b1;
      clear_scan();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // sample both transactions and run the watchdog
  always @(posedge clk) begin
    if (rst) begin
      byte_taken   <= 1'b0;
      quiet_cycles <= 0;
      clear_scan();
    end else begin
      byte_taken <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (unit_reports.size() == 0) begin
          $error("result with nothing expected: tdata %h status %0d", m_axis_tdata,
                 m_axis_tuser);
          mismatches++;
        end else begin
          want = unit_reports.pop_front();
          if (want.status == ST_RECORD) records_seen++;
          check_field("code_offset", want.code_offset, m_axis_tdata[23:0]);
          check_field("code_size", want.code_size, m_axis_tdata[26:24]);
          check_field("payload_offset", want.payload_offset, m_axis_tdata[50:27]);
          check_field("payload_size", want.payload_size, m_axis_tdata[74:51]);
          check_field("status", want.status, m_axis_tuser);
          check_field("is_last", want.is_last, m_axis_tlast);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        bytes_scanned++;
        if (s_axis_tlast) streams_done++;
        scan_byte({s_axis_tdata, s_axis_tlast}, emit, report);
        if (emit) unit_reports.push_back(report);
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // byte source
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || byte_taken) begin
      if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        {s_axis_tdata, s_axis_tlast} <= byte_queue.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result sink, with one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_ask && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic add_byte(input logic [7:0] b, input logic eos);
    item_t it;
    it.data_byte     = b;
    it.end_of_stream = eos;
    byte_queue.push_back(it);
    bytes_queued++;
  endtask

  function automatic logic [7:0] pick_byte();
    int sel;
    sel = $urandom_range(9);
    if (sel < 4) return 8'h00;
    if (sel == 4) return 8'h01;
    return 8'($urandom_range(255));
  endfunction

  task automatic add_codes(input logic [7:0] seq[], input bit eos_at_end);
    int k;
    for (k = 0; k < seq.size(); k++) add_byte(seq[k], eos_at_end && k == seq.size() - 1);
  endtask

  task automatic queue_random(input int target);
    int goal, units, u, len;
    goal = bytes_queued + target;
    while (bytes_queued < goal) begin
      if ($urandom_range(9) < 8) begin
        units = $urandom_range(4);
        for (u = 0; u < units; u++) begin
          len = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
          repeat (len) add_byte(8'h00, 1'b0);
          if ($urandom_range(1)) add_byte(8'h00, 1'b0);
          add_byte(8'h00, 1'b0);
          add_byte(8'h00, 1'b0);
          add_byte(8'h01, 1'b0);
          len = $urandom_range(8);
          repeat (len) add_byte(pick_byte(), 1'b0);
        end
        if (units == 0) begin
          len = $urandom_range(1, 6);
          repeat (len) add_byte(pick_byte(), 1'b0);
        end
        add_byte(pick_byte(), 1'b1);
      end else begin
        len = $urandom_range(3, 15);
        repeat (len) add_byte(8'($urandom_range(255)), $urandom_range(19) == 0);
      end
    end
  endtask

  task automatic drain_bytes();
    while (byte_queue.size() > 0 || s_axis_tvalid) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // lone byte, no code anywhere
    add_byte(8'h00, 1'b1);
    // short code, unit closed by a code on the final byte
    add_codes('{8'h00, 8'h00, 8'h01, 8'hAA, 8'hFF, 8'h00, 8'h00, 8'h01}, 1'b1);
    // long code after a stray zero, then a short code, unit closed at the end
    add_codes('{8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'h00, 8'h00, 8'h01, 8'h80},
              1'b1);
    // record, then back-to-back codes ending the stream with an empty unit
    add_codes('{8'h00, 8'h00, 8'h01, 8'h7F, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01},
              1'b1);
    queue_random(560);
    drain_bytes();

    send_idle_pct = 87;
    recv_idle_pct = 7;
    queue_random(580);
    drain_bytes();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_ask      = 1'b1;
    queue_random(580);
    drain_bytes();

    while (unit_reports.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Scanned %0d bytes over %0d complete streams under three handshake patterns.",
             bytes_scanned, streams_done);
    $display("Checked %0d results, %0d of them unit records.", results_seen, records_seen);
    if (mismatches == 0 && unit_reports.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
